// File: hdl/kqt_pkg.sv
package kqt_pkg;

    typedef enum logic [1:0] {
        OP_FIND  = 2'd0,
        OP_TAKE  = 2'd1,
        OP_PUT   = 2'd2,
        OP_CLEAR = 2'd3
    } t_kqt_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_kqt_status;

    localparam int KEY_W  = 16;
    localparam int AMT_W  = 16;
    localparam int HELD_W = 7;

    typedef struct packed {
        t_kqt_op            operation;
        logic [KEY_W-1:0]   item_key;
        logic [AMT_W-1:0]   amount;
    } t_kqt_in;

    typedef struct packed {
        t_kqt_status        status;
        logic [HELD_W-1:0]  entries_held;
    } t_kqt_out;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [AMT_W-1:0]   amount;
    } t_kqt_entry;

    typedef struct packed {
        logic found;
        logic ok;
        logic del;
    } t_kqt_chain;

endpackage

// File: hdl/kqt_cell.sv
module kqt_cell
    import kqt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 7
) (
    input  logic        i_clk,
    input  logic        i_exec,
    input  t_kqt_in     i_cmd,
    input  logic [CW-1:0] i_count,
    input  t_kqt_entry  i_next,
    input  t_kqt_chain  i_chain,
    output t_kqt_entry  o_entry,
    output t_kqt_chain  o_chain
);

    t_kqt_entry r_entry;
    logic       occ;
    logic       match;
    logic       first;
    logic       ge;
    logic       del_here;

    always_comb begin
        occ      = i_count > CW'(INDEX);
        match    = occ && (r_entry.key == i_cmd.item_key);
        first    = match && !i_chain.found;
        ge       = r_entry.amount >= i_cmd.amount;
        del_here = first && ((r_entry.amount == i_cmd.amount) || (i_cmd.amount == '0));
        o_chain.found = i_chain.found || match;
        o_chain.ok    = i_chain.ok || (first && ge);
        o_chain.del   = i_chain.del || del_here;
    end

    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            unique case (i_cmd.operation)
                OP_TAKE: begin
                    if (i_chain.del || del_here) begin
                        r_entry <= i_next;
                    end else if (first && ge) begin
                        r_entry.amount <= r_entry.amount - i_cmd.amount;
                    end
                end
                OP_PUT: begin
                    if (i_count == CW'(INDEX)) begin
                        r_entry.key    <= i_cmd.item_key;
                        r_entry.amount <= i_cmd.amount;
                    end
                end
                OP_FIND, OP_CLEAR: begin
                end
            endcase
        end
    end

    assign o_entry = r_entry;

endmodule

// File: hdl/keyed_quantity_table.sv
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-------------------------------
// command   | start, busy (out)         | i_cmd    (t_kqt_in)
// result    | o_strobe (one cycle)      | o_result (t_kqt_out)
//
// A command is taken at an edge where start is high and busy is low; busy then
// stays high for one cycle, in which every cell compares, shifts or updates at once.
// The result strobe follows in the next cycle; no new command is taken while busy is high.
// Reset is synchronous and clears the count and control state; entry storage is not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module keyed_quantity_table
    import kqt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_kqt_in  i_cmd,
    output logic     o_strobe,
    output t_kqt_out o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state       r_state;
    t_state       n_state;
    t_kqt_in      r_cmd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic         r_strobe;
    t_kqt_status  r_status;
    t_kqt_status  n_status;
    logic         exec;
    logic [CW+HELD_W-1:0] held_ext;

    t_kqt_entry entries [CAPACITY];
    t_kqt_chain chain   [CAPACITY+1];

    assign exec     = (r_state == S_EXEC);
    assign chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_kqt_entry next_entry;
        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = entries[g];
        end else begin : g_mid
            assign next_entry = entries[g+1];
        end
        kqt_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_exec  (exec),
            .i_cmd   (r_cmd),
            .i_count (r_count),
            .i_next  (next_entry),
            .i_chain (chain[g]),
            .o_entry (entries[g]),
            .o_chain (chain[g+1])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = ST_OK;
        unique case (r_cmd.operation)
            OP_FIND: begin
                n_status = chain[CAPACITY].ok ? ST_OK : ST_MISS;
            end
            OP_TAKE: begin
                n_status = chain[CAPACITY].ok ? ST_OK : ST_MISS;
                if (chain[CAPACITY].del) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_PUT: begin
                if (r_count == CW'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
        endcase
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= exec;
            if (exec) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_cmd <= i_cmd;
        end
        if (exec) begin
            r_status <= n_status;
        end
    end

    assign held_ext = {{HELD_W{1'b0}}, r_count};

    assign busy                  = exec;
    assign o_strobe              = r_strobe;
    assign o_result.status       = r_status;
    assign o_result.entries_held = held_ext[HELD_W-1:0];

endmodule

// File: hdl/kqt_checker.sv
module kqt_checker
    import kqt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     busy,
    input  t_kqt_in  i_cmd,
    input  logic     o_strobe,
    input  t_kqt_out o_result
);

    // Every accepted beat raises busy and yields exactly one result beat after the busy cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted command did not raise busy");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("result beat missing after busy cycle");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n)) |-> $past(busy))
        else $error("result beat without a command");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_result.status != 2'd3) &&
                      ((CAPACITY > 127) ||
                       (o_result.entries_held <= HELD_W'(CAPACITY)))))
        else $error("result out of range");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n, 2) && $past(start && !busy, 2) &&
         ($past(i_cmd.operation, 2) == OP_CLEAR)) |-> (o_result.entries_held == '0))
        else $error("clear left entries in the list");

endmodule

bind keyed_quantity_table kqt_checker #(.CAPACITY(CAPACITY)) u_kqt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
